/* hw/rtl/gyro_encoder_dead_reckoning_unit_assert.svh */
// Assertion macros for the dead reckoning unit checker
`ifndef GYRO_ENCODER_DEAD_RECKONING_UNIT_ASSERT_SVH
`define GYRO_ENCODER_DEAD_RECKONING_UNIT_ASSERT_SVH
// Implication checked on every clock edge outside reset
`define GEDR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset
`define GEDR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

/* hw/rtl/gedr_pkg.sv */
// Shared types and constants for the dead reckoning unit
`default_nettype none
package gedr_pkg;
  localparam int ANGLE_BITS   = 32;
  localparam int CORDIC_STEPS = 16;
  localparam int TABLE_LEN    = 24;
  localparam int STEP_W       = $clog2(CORDIC_STEPS + 1);

  localparam logic [31:0] RATE_SCALE_RST = 32'd390937467;
  localparam logic [31:0] DIST_TICK_RST  = 32'd2284503;
  localparam logic signed [33:0] CORDIC_START = 34'sd652032874;

  localparam logic REG_RATE_SCALE = 1'b0;
  localparam logic REG_DIST_TICK  = 1'b1;

  // Mask that clears angle bits below the kept resolution
  localparam logic [31:0] ANGLE_MASK = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);

  // One accepted sample as it sits in the queue
  typedef struct packed {
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
    logic signed [15:0] ticks;
    logic [23:0]        elapsed;
  } sample_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [31:0]        yaw;
    logic [31:0]        pitch;
    logic [31:0]        roll;
  } result_t;

  function automatic logic [31:0] atan_turns(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0: v = 32'd536870912;  5'd1: v = 32'd316933406;
      5'd2: v = 32'd167458907;  5'd3: v = 32'd85004756;
      5'd4: v = 32'd42667331;   5'd5: v = 32'd21354465;
      5'd6: v = 32'd10679838;   5'd7: v = 32'd5340245;
      5'd8: v = 32'd2670163;    5'd9: v = 32'd1335087;
      5'd10: v = 32'd667544;    5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;    5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;     5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;     5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;       5'd21: v = 32'd326;
      5'd22: v = 32'd163;       5'd23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction
endpackage
`default_nettype wire

/* hw/rtl/gedr_front.sv */
// Input side: accepts samples and holds them in a two-entry queue
`default_nettype none
module gedr_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire gedr_pkg::sample_t in_sample,
  output logic                  q_valid,
  output gedr_pkg::sample_t     q_sample,
  input  wire logic             q_take
);
  import gedr_pkg::*;

  sample_t   mem_r [2];
  logic      wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic      push, pop;

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_valid && q_take;
  assign q_sample = mem_r[rd_ptr_r];

  // Write the sample into the queue
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_sample;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/gedr_back.sv */
// Compute side: angle integration, CORDIC and position update
`default_nettype none
module gedr_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [31:0]       rate_scale,
  input  wire logic [31:0]       dist_tick,
  input  wire logic              q_valid,
  input  wire gedr_pkg::sample_t q_sample,
  output logic                   q_take,
  output logic                   res_valid,
  output gedr_pkg::result_t      res,
  input  wire logic              res_stall
);
  import gedr_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_P1   = 9'b000000010,
    S_P2   = 9'b000000100,
    S_ACC  = 9'b000001000,
    S_CORD = 9'b000010000,
    S_QUAD = 9'b000100000,
    S_MULX = 9'b001000000,
    S_MULY = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  sample_t smp_r;
  logic [1:0] axis_r;
  logic signed [39:0] rt_r;
  logic [31:0] yaw_r, pitch_r, roll_r;
  logic signed [31:0] x_r, y_r;
  logic signed [33:0] cx_r, cy_r, cz_r;
  logic [STEP_W-1:0] step_r;
  logic [1:0] quad_r;
  logic signed [31:0] dh_r;
  logic signed [33:0] cos_r, sin_r;
  logic [31:0] inc_r;
  logic out_valid_r;

  logic signed [15:0] cur_rate;
  logic signed [39:0] rt_prod;
  logic signed [72:0] inc_prod;
  logic signed [33:0] sh_x, sh_y, at;
  logic signed [63:0] mprod;
  logic signed [51:0] mshift;
  logic signed [52:0] msum;
  logic signed [31:0] msat;
  logic signed [31:0] macc;
  logic [1:0] q_of_yaw;

  assign q_take = (state_r == S_IDLE);
  assign res_valid = out_valid_r;

  always_comb begin
    case (axis_r)
      2'd0:    cur_rate = smp_r.gyro_z;
      2'd1:    cur_rate = smp_r.gyro_x;
      default: cur_rate = smp_r.gyro_y;
    endcase
  end

  // Rate times elapsed (fits in 40 bits), then times scale
  assign rt_prod  = cur_rate * $signed({1'b0, smp_r.elapsed});
  assign inc_prod = rt_r * $signed({1'b0, rate_scale});

  // Quadrant split of the new yaw
  assign q_of_yaw = 2'((yaw_r + 32'h2000_0000) >> 30);

  assign sh_x = cx_r >>> step_r;
  assign sh_y = cy_r >>> step_r;
  assign at   = $signed({2'b00, atan_turns(5'(step_r))});

  // Position multiply and saturating add; cos and sin stay within 32 bits
  always_comb begin
    mprod  = dh_r * ((state_r == S_MULX) ? $signed(cos_r[31:0]) : $signed(sin_r[31:0]));
    mshift = 52'(mprod >>> 30);
    macc   = (state_r == S_MULX) ? x_r : y_r;
    msum   = 53'(mshift) + 53'(macc);
    if (msum > 53'sd2147483647)        msat = 32'sh7fffffff;
    else if (msum < -53'sd2147483648)  msat = 32'sh80000000;
    else                               msat = msum[31:0];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (q_valid) state_nxt = S_P1;
      S_P1:   state_nxt = S_P2;
      S_P2:   state_nxt = S_ACC;
      S_ACC:  if (axis_r == 2'd2) state_nxt = S_CORD; else state_nxt = S_P1;
      S_CORD: if (step_r == STEP_W'(CORDIC_STEPS - 1)) state_nxt = S_QUAD;
      S_QUAD: state_nxt = S_MULX;
      S_MULX: state_nxt = S_MULY;
      S_MULY: state_nxt = S_OUT;
      S_OUT:  if (!out_valid_r || !res_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Sequence one sample through the datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      yaw_r <= '0; pitch_r <= '0; roll_r <= '0;
      x_r <= '0; y_r <= '0;
      axis_r <= '0; step_r <= '0;
    end else begin
      state_r <= state_nxt;
      // Load a new result or drop the one just transferred
      if (state_r == S_OUT && (!out_valid_r || !res_stall)) out_valid_r <= 1'b1;
      else if (out_valid_r && !res_stall) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            smp_r  <= q_sample;
            axis_r <= 2'd0;
            dh_r   <= 32'(48'(q_sample.ticks * $signed({1'b0, dist_tick})) >>> 16);
          end
        end
        S_P1: rt_r <= rt_prod;
        S_P2: inc_r <= inc_prod[63:32];
        S_ACC: begin
          case (axis_r)
            2'd0:    yaw_r   <= (yaw_r + inc_r) & ANGLE_MASK;
            2'd1:    pitch_r <= (pitch_r + inc_r) & ANGLE_MASK;
            default: roll_r  <= (roll_r + inc_r) & ANGLE_MASK;
          endcase
          axis_r <= axis_r + 2'd1;
          step_r <= '0;
          cx_r   <= CORDIC_START;
          cy_r   <= '0;
          // yaw settles before the first pitch step, so load residual after it
          if (axis_r == 2'd2) begin
            quad_r <= q_of_yaw;
            cz_r   <= 34'($signed(yaw_r - {q_of_yaw, 30'd0}));
          end
        end
        S_CORD: begin
          if (!cz_r[33]) begin
            cx_r <= cx_r - sh_y; cy_r <= cy_r + sh_x; cz_r <= cz_r - at;
          end else begin
            cx_r <= cx_r + sh_y; cy_r <= cy_r - sh_x; cz_r <= cz_r + at;
          end
          step_r <= step_r + STEP_W'(1);
        end
        S_QUAD: begin
          case (quad_r)
            2'd0:    begin cos_r <= cx_r;  sin_r <= cy_r;  end
            2'd1:    begin cos_r <= -cy_r; sin_r <= cx_r;  end
            2'd2:    begin cos_r <= -cx_r; sin_r <= -cy_r; end
            default: begin cos_r <= cy_r;  sin_r <= -cx_r; end
          endcase
        end
        S_MULX: x_r <= msat;
        S_MULY: y_r <= msat;
        S_OUT: begin
          if (!out_valid_r || !res_stall) begin
            res <= '{pos_x: x_r, pos_y: y_r, yaw: yaw_r, pitch: pitch_r, roll: roll_r};
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/gyro_encoder_dead_reckoning_unit.sv */
// Top level of the gyro and wheel-encoder dead reckoning unit
//   channel | direction | handshake        | payload
//   in      | input     | in_valid/stall   | gyro x,y,z, encoder ticks, elapsed us
//   out     | output    | out_valid/stall  | pos x,y, yaw, pitch, roll
//   cfg     | input     | cfg_we           | rate_scale, distance_per_tick
// The compute side takes one sample at a time: one load step, 3 axes of
// 3 steps (multiply, multiply, accumulate), 16 CORDIC iterations, quadrant
// fold, two position multiply steps, one output step.
// A two-entry input queue and the output register let both sides stall apart.
// Reset (synchronous, rst_n low) zeros angles and positions, loads defaults.
`default_nettype none
module gyro_encoder_dead_reckoning_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic [31:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [15:0] in_gyro_x,
  input  wire logic signed [15:0] in_gyro_y,
  input  wire logic signed [15:0] in_gyro_z,
  input  wire logic signed [15:0] in_encoder_ticks,
  input  wire logic [23:0]        in_elapsed_us,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      out_pos_x,
  output logic signed [31:0]      out_pos_y,
  output logic [31:0]             out_yaw_angle,
  output logic [31:0]             out_pitch_angle,
  output logic [31:0]             out_roll_angle
);
  import gedr_pkg::*;

  logic [31:0] rate_scale_r, dist_tick_r;
  sample_t in_sample, q_sample;
  result_t res;
  logic q_valid, q_take;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_scale_r <= RATE_SCALE_RST;
      dist_tick_r  <= DIST_TICK_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RATE_SCALE: rate_scale_r <= cfg_data;
        REG_DIST_TICK:  dist_tick_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_sample = '{gyro_x: in_gyro_x, gyro_y: in_gyro_y, gyro_z: in_gyro_z,
                       ticks: in_encoder_ticks, elapsed: in_elapsed_us};

  gedr_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_sample,
    .q_valid, .q_sample, .q_take
  );

  gedr_back u_back (
    .clk, .rst_n, .rate_scale(rate_scale_r), .dist_tick(dist_tick_r),
    .q_valid, .q_sample, .q_take,
    .res_valid(out_valid), .res, .res_stall(out_stall)
  );

  assign out_pos_x       = res.pos_x;
  assign out_pos_y       = res.pos_y;
  assign out_yaw_angle   = res.yaw;
  assign out_pitch_angle = res.pitch;
  assign out_roll_angle  = res.roll;
endmodule
`default_nettype wire

/* hw/rtl/gedr_checker.sv */
// Port-level checker for the dead reckoning unit, bound to the top level
`default_nettype none
`include "gyro_encoder_dead_reckoning_unit_assert.svh"
module gedr_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] out_yaw_angle
);
  // A stalled result stays valid
  `GEDR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
  // A stalled result keeps its heading
  `GEDR_ASSERT_NEXT(a_yaw_hold, clk, rst_n, out_valid && out_stall, $stable(out_yaw_angle))
  // Right after reset no result is offered
  `GEDR_ASSERT_IMP(a_rst_empty, clk, rst_n, $rose(rst_n), !out_valid)
  // Right after reset the input side is open
  `GEDR_ASSERT_IMP(a_rst_open, clk, rst_n, $rose(rst_n), !in_stall)
endmodule

bind gyro_encoder_dead_reckoning_unit gedr_checker u_gedr_checker (
  .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .out_yaw_angle
);
`default_nettype wire

/* test/tb.sv */
// Testbench for the gyro and wheel-encoder dead reckoning unit
`timescale 1ns / 100ps
module tb;
  import gedr_pkg::*;

  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 64;
  localparam int N_DIRECTED = 14;

  // Phases of sender and receiver idling
  typedef enum logic [1:0] {
    PH_NONE, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH
  } phase_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_index;
  logic [31:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic signed [15:0] in_gyro_x, in_gyro_y, in_gyro_z, in_encoder_ticks;
  logic [23:0] in_elapsed_us;
  logic out_valid;
  logic out_stall;
  logic signed [31:0] out_pos_x, out_pos_y;
  logic [31:0] out_yaw_angle, out_pitch_angle, out_roll_angle;

  gyro_encoder_dead_reckoning_unit dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_gyro_x(in_gyro_x), .in_gyro_y(in_gyro_y), .in_gyro_z(in_gyro_z),
    .in_encoder_ticks(in_encoder_ticks), .in_elapsed_us(in_elapsed_us),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_pos_x(out_pos_x), .out_pos_y(out_pos_y),
    .out_yaw_angle(out_yaw_angle), .out_pitch_angle(out_pitch_angle),
    .out_roll_angle(out_roll_angle)
  );

  // Directed row: sample plus optional typed-in result
  typedef struct {
    sample_t smp;
    bit      has_exp;
    result_t exp;
  } row_t;

  // Predictor state and register copies
  logic [31:0] rate_scale_q, dist_tick_q;
  logic signed [31:0] pos_x_q, pos_y_q;
  logic [31:0] yaw_q, pitch_q, roll_q;

  result_t pending_results[$];
  phase_t phase;
  int errors;
  int idle_cycles;
  bit timed_out;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic signed [63:0] floor_shift(logic signed [63:0] v, int s);
    return v >>> s;
  endfunction

  function automatic logic [31:0] integrate_angle(logic [31:0] ang,
                                                  logic signed [15:0] rate,
                                                  logic [23:0] dt);
    logic signed [63:0] p;
    logic [63:0] prod;
    p = 64'(rate) * $signed({40'd0, dt});
    prod = p * {32'd0, rate_scale_q};
    return (ang + prod[63:32]) & ANGLE_MASK;
  endfunction

  // Fixed-gain CORDIC rotation, quadrant folded afterwards
  task automatic heading_sin_cos(input logic [31:0] a,
                                 output logic signed [63:0] c,
                                 output logic signed [63:0] s);
    logic [1:0] quad;
    logic [31:0] u;
    logic signed [63:0] z, x, y, dx, dy;
    quad = 2'((a + 32'h2000_0000) >> 30);
    u = a - ({30'd0, quad} << 30);
    z = 64'($signed(u));
    x = 64'(CORDIC_START);
    y = 0;
    for (int i = 0; i < CORDIC_STEPS && i < TABLE_LEN; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= $signed({32'd0, atan_turns(5'(i))});
      end else begin
        x += dx; y -= dy; z += $signed({32'd0, atan_turns(5'(i))});
      end
    end
    case (quad)
      2'd0: begin c = x; s = y; end
      2'd1: begin c = -y; s = x; end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endtask

  function automatic logic signed [31:0] sat_add32(logic signed [31:0] a,
                                                   logic signed [63:0] b);
    logic signed [63:0] r;
    r = 64'(a) + b;
    if (r > 64'sd2147483647) return 32'sh7fff_ffff;
    if (r < -64'sd2147483648) return 32'sh8000_0000;
    return r[31:0];
  endfunction

  // Advance the model by one sample and return the new pose
  task automatic predict_pose(input sample_t smp, output result_t res);
    logic signed [63:0] c, s, d, dh;
    yaw_q = integrate_angle(yaw_q, smp.gyro_z, smp.elapsed);
    pitch_q = integrate_angle(pitch_q, smp.gyro_x, smp.elapsed);
    roll_q = integrate_angle(roll_q, smp.gyro_y, smp.elapsed);
    heading_sin_cos(yaw_q, c, s);
    d = 64'(smp.ticks) * $signed({32'd0, dist_tick_q});
    dh = floor_shift(d, 16);
    pos_x_q = sat_add32(pos_x_q, floor_shift(dh * c, 30));
    pos_y_q = sat_add32(pos_y_q, floor_shift(dh * s, 30));
    res.pos_x = pos_x_q;
    res.pos_y = pos_y_q;
    res.yaw = yaw_q;
    res.pitch = pitch_q;
    res.roll = roll_q;
  endtask

  function automatic sample_t rand_sample();
    sample_t smp;
    int pick;
    pick = $urandom_range(0, 9);
    smp.gyro_x = 16'($urandom);
    smp.gyro_y = 16'($urandom);
    smp.gyro_z = 16'($urandom);
    smp.ticks = 16'($urandom);
    // Mostly realistic sample periods, sometimes any value
    if (pick < 6) smp.elapsed = 24'($urandom_range(0, 20000));
    else smp.elapsed = 24'($urandom);
    if (pick == 9) smp.ticks = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
    return smp;
  endfunction

  // Write one register while the block is idle
  task automatic write_reg(input logic idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_RATE_SCALE) rate_scale_q = val;
    else dist_tick_q = val;
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // Present one sample and hold it until the transfer
  task automatic send_sample(input sample_t smp);
    result_t res;
    @(negedge clk);
    while ((phase == PH_SEND_IDLE || phase == PH_BOTH) &&
           $urandom_range(0, 99) < 87) @(negedge clk);
    in_valid <= 1'b1;
    in_gyro_x <= smp.gyro_x;
    in_gyro_y <= smp.gyro_y;
    in_gyro_z <= smp.gyro_z;
    in_encoder_ticks <= smp.ticks;
    in_elapsed_us <= smp.elapsed;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_pose(smp, res);
    pending_results.push_back(res);
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Drive the receiver stall
  always @(negedge clk) begin
    if (phase == PH_RECV_STALL || phase == PH_BOTH)
      out_stall <= ($urandom_range(0, 99) < 87);
    else
      out_stall <= 1'b0;
  end

  // Compare each result transfer against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transfer");
        errors++;
      end else begin
        result_t e;
        e = pending_results.pop_front();
        if (out_pos_x !== e.pos_x) begin
          $error("pos_x expected %0d got %0d", e.pos_x, out_pos_x); errors++;
        end
        if (out_pos_y !== e.pos_y) begin
          $error("pos_y expected %0d got %0d", e.pos_y, out_pos_y); errors++;
        end
        if (out_yaw_angle !== e.yaw) begin
          $error("yaw_angle expected %0h got %0h", e.yaw, out_yaw_angle); errors++;
        end
        if (out_pitch_angle !== e.pitch) begin
          $error("pitch_angle expected %0h got %0h", e.pitch, out_pitch_angle);
          errors++;
        end
        if (out_roll_angle !== e.roll) begin
          $error("roll_angle expected %0h got %0h", e.roll, out_roll_angle); errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no transfer
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    row_t rows[N_DIRECTED];
    result_t typed;
    sample_t smp;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_RATE_SCALE;
    cfg_data = '0;
    in_valid = 1'b0;
    in_gyro_x = '0; in_gyro_y = '0; in_gyro_z = '0;
    in_encoder_ticks = '0;
    in_elapsed_us = '0;
    out_stall = 1'b0;
    phase = PH_NONE;
    errors = 0;
    idle_cycles = 0;
    timed_out = 1'b0;
    rate_scale_q = RATE_SCALE_RST;
    dist_tick_q = DIST_TICK_RST;
    pos_x_q = 0; pos_y_q = 0;
    yaw_q = 0; pitch_q = 0; roll_q = 0;

    // Watchdog
    fork
      begin
        wait (idle_cycles >= IDLE_LIMIT);
        timed_out = 1'b1;
      end
    join_none

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed table: zero sample first, then extremes and zero elapsed time, then yaw rate steps
    typed = '0;
    rows[0] = '{smp: '0, has_exp: 1'b1, exp: typed};
    rows[1] = '{smp: '{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh0000, 24'hff_ffff},
                has_exp: 1'b0, exp: typed};
    rows[2] = '{smp: '{16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 24'h00_0000},
                has_exp: 1'b0, exp: typed};
    rows[3] = '{smp: '{16'sh0000, 16'sh0000, 16'sh0000, 16'sh8000, 24'h00_0001},
                has_exp: 1'b0, exp: typed};
    rows[4] = '{smp: '{16'shffff, 16'sh0001, 16'sh4000, 16'sh7fff, 24'h00_2710},
                has_exp: 1'b0, exp: typed};
    rows[5] = '{smp: '{16'sh0001, 16'shffff, 16'shc000, 16'sh8000, 24'h80_0000},
                has_exp: 1'b0, exp: typed};
    for (int i = 6; i < N_DIRECTED; i++)
      rows[i] = '{smp: '{16'sh0000, 16'sh0000, 16'(i * 4000), 16'sh7fff, 24'h00_1388},
                  has_exp: 1'b0, exp: typed};

    for (int i = 0; i < N_DIRECTED; i++) begin
      send_sample(rows[i].smp);
      if (rows[i].has_exp && pending_results[$] != rows[i].exp) begin
        $error("predictor disagrees with typed result on row %0d", i);
        errors++;
      end
    end
    wait_drained();

    // Large scale and distance drive positions into saturation
    write_reg(REG_RATE_SCALE, 32'hffff_ffff);
    write_reg(REG_DIST_TICK, 32'hffff_ffff);
    for (int i = 0; i < 12; i++) begin
      smp = rand_sample();
      smp.ticks = (i < 6) ? 16'sh7fff : 16'sh8000;
      send_sample(smp);
    end
    wait_drained();
    write_reg(REG_RATE_SCALE, 32'd0);
    write_reg(REG_DIST_TICK, 32'd0);
    for (int i = 0; i < 6; i++) send_sample(rand_sample());
    wait_drained();

    // Random phases, each with its own register setting
    for (int p = 0; p < 4; p++) begin
      phase = phase_t'(p);
      write_reg(REG_RATE_SCALE, (p == 1) ? RATE_SCALE_RST : $urandom);
      write_reg(REG_DIST_TICK, (p == 3) ? DIST_TICK_RST : $urandom_range(0, 32'h00ff_ffff));
      for (int i = 0; i < 120; i++) begin
        send_sample(rand_sample());
        if (i == 60) wait_drained();
      end
      wait_drained();
    end
    phase = PH_NONE;

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && !timed_out && pending_results.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  // End the run on a stuck block
  initial begin
    wait (timed_out);
    $display("FAIL");
    $finish;
  end
endmodule
